// ----- rtl/core/mbe_pkg.sv -----
// shared constants, register indexes and control and status types of the escape-time block
package mbe_pkg;

  localparam int INT_BITS      = 6;
  localparam int MAX_SIZE_DEF  = 8192;
  localparam int FRAC_BITS_DEF = 26;

  localparam int PIX_W      = 13;
  localparam int SIZE_W     = 14;
  localparam int ITER_W     = 16;
  localparam int SHADE_W    = 9;
  localparam int SHADE_SH   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = SIZE_W'(5000);
  localparam logic [ITER_W-1:0] MAX_ITER_RST   = ITER_W'(500);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'b1;

  typedef struct packed {
    logic load;
    logic sq_re;
    logic sq_im;
    logic step;
  } mbe_orbit_ctl_t;

  typedef struct packed {
    logic big;
    logic outside;
  } mbe_orbit_sts_t;

endpackage

// ----- rtl/core/mbe_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module mbe_div #(
  parameter int DVW = 41,
  parameter int DSW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = (DVW > 1) ? $clog2(DVW) : 1;

  logic           run;
  logic [CW-1:0]  cnt;
  logic [DVW-1:0] dvd;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [DSW:0]   shifted;
  logic [DSW+1:0] diff;
  logic           ge;

  always_comb begin
    shifted = {rem, dvd[DVW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    ge      = ~diff[DSW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DVW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[DVW-2:0], ge};
      rem <= ge ? diff[DSW-1:0] : shifted[DSW-1:0];
    end
  end

  assign quotient = dvd;

endmodule

// ----- rtl/core/mbe_orbit.sv -----
// orbit datapath: z and c registers around one shared fixed-point multiplier
module mbe_orbit
  #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  mbe_pkg::mbe_orbit_ctl_t                           ctl,
  input  logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0]     c_re_in,
  input  logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0]     c_im_in,
  output mbe_pkg::mbe_orbit_sts_t                           sts
);
  import mbe_pkg::*;

  localparam int QW  = FRAC_BITS + INT_BITS;
  localparam int SW2 = QW + 2;

  localparam logic signed [QW-1:0]  TWO_Q  = QW'(2) << FRAC_BITS;
  localparam logic signed [QW-1:0]  NTWO_Q = -TWO_Q;
  localparam logic signed [QW:0]    FOUR_Q = (QW + 1)'(4) << FRAC_BITS;
  localparam logic signed [QW-1:0]  QMAX   = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0]  QMIN   = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [SW2-1:0] SMAX   = SW2'(QMAX);
  localparam logic signed [SW2-1:0] SMIN   = SW2'(QMIN);

  logic signed [QW-1:0]     cre, cim, zre, zim, sr, si;
  logic signed [QW-1:0]     ma, mb, pq;
  logic signed [2*QW-1:0]   prod;
  logic signed [QW:0]       mag2;
  logic signed [SW2-1:0]    sre, sim;
  logic signed [QW-1:0]     nre, nim;

  // operand select for the shared multiplier
  always_comb begin
    if (ctl.sq_re) begin
      ma = zre;
      mb = zre;
    end else if (ctl.sq_im) begin
      ma = zim;
      mb = zim;
    end else begin
      ma = zre;
      mb = zim;
    end
    prod = ma * mb;
    pq   = $signed(prod[FRAC_BITS+QW-1:FRAC_BITS]);
  end

  always_comb begin
    sre = SW2'(sr) - SW2'(si) + SW2'(cre);
    sim = (SW2'(pq) <<< 1) + SW2'(cim);
    if (sre > SMAX) nre = QMAX;
    else if (sre < SMIN) nre = QMIN;
    else nre = sre[QW-1:0];
    if (sim > SMAX) nim = QMAX;
    else if (sim < SMIN) nim = QMIN;
    else nim = sim[QW-1:0];
  end

  always_comb begin
    mag2        = (QW + 1)'(sr) + (QW + 1)'(si);
    sts.big     = (zre > TWO_Q) || (zre < NTWO_Q) || (zim > TWO_Q) || (zim < NTWO_Q);
    sts.outside = mag2 > FOUR_Q;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cre <= c_re_in;
      cim <= c_im_in;
      zre <= c_re_in;
      zim <= c_im_in;
    end else if (ctl.sq_re) begin
      sr <= pq;
    end else if (ctl.sq_im) begin
      si <= pq;
    end else if (ctl.step) begin
      zre <= nre;
      zim <= nim;
    end
  end

endmodule

// ----- rtl/core/mandelbrot_escape_time.sv -----
// escape-time pixel evaluator: sequencer, config registers and coordinate scaling
// the work per word is done by the shared bit-serial divider, which runs once per
// coordinate and once for the shade (not when max_iter is 0), and by the shared
// multiplier, three passes per step
// throughput: one word at a time, start is taken only while busy is low
// reset: rst is synchronous, active high; it idles the sequencer and loads
// image_size 5000 and max_iter 500; the result strobe done is never held off
module mandelbrot_escape_time
  #(
  parameter int MAX_SIZE  = mbe_pkg::MAX_SIZE_DEF,
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mbe_pkg::PIX_W-1:0]        row,
  input  logic [mbe_pkg::PIX_W-1:0]        col,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output logic [mbe_pkg::SHADE_W-1:0]      shade,
  output logic [mbe_pkg::ITER_W-1:0]       iterations
);
  import mbe_pkg::*;

  localparam int QW  = FRAC_BITS + INT_BITS;
  localparam int DVW = FRAC_BITS + PIX_W + 2;
  localparam int DSW = ITER_W;

  localparam logic [DVW-1:0]       Q_HALF = {{(DVW-1){1'b0}}, 1'b1} << (QW - 1);
  localparam logic signed [QW-1:0] QMAX   = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN   = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DIV_RE    = 7'b0000010,
    S_DIV_IM    = 7'b0000100,
    S_SQ_RE     = 7'b0001000,
    S_SQ_IM     = 7'b0010000,
    S_CROSS     = 7'b0100000,
    S_DIV_SHADE = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0]       image_size;
  logic [ITER_W-1:0]       max_iter;
  logic [SIZE_W-1:0]       size_eff;
  logic [SIZE_W-1:0]       size;
  logic [ITER_W-1:0]       lim;
  logic [PIX_W-1:0]        col_q;
  logic [ITER_W-1:0]       k;
  logic                    sgn;
  logic signed [QW-1:0]    cre;
  logic signed [QW-1:0]    c_sat;

  logic [PIX_W-1:0]        pix;
  logic [SIZE_W-1:0]       pix_size;
  logic signed [PIX_W:0]   d;
  logic [PIX_W-1:0]        d_mag;

  logic                    div_start;
  logic [DVW-1:0]          div_dividend;
  logic [DSW-1:0]          div_divisor;
  logic                    div_done;
  logic [DVW-1:0]          div_q;

  logic                    finish;
  mbe_orbit_ctl_t          ctl;
  mbe_orbit_sts_t          sts;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= IMAGE_SIZE_RST;
      max_iter   <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_SIZE: image_size <= cfg_data[SIZE_W-1:0];
        REG_MAX_ITER:   max_iter   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_size == '0) size_eff = SIZE_W'(1);
    else if (32'(image_size) > MAX_SIZE) size_eff = SIZE_W'(MAX_SIZE);
    else size_eff = image_size;
  end

  // pixel offset from the image center, row on accept and col afterwards
  always_comb begin
    pix      = (state == S_IDLE) ? row : col_q;
    pix_size = (state == S_IDLE) ? size_eff : size;
    d        = $signed({1'b0, pix}) - $signed({1'b0, pix_size[SIZE_W-1:1]});
    d_mag    = d[PIX_W] ? PIX_W'(-d) : d[PIX_W-1:0];
  end

  // saturate the divider quotient into a signed coordinate
  always_comb begin
    if (!sgn) begin
      c_sat = (div_q >= Q_HALF) ? QMAX : $signed(div_q[QW-1:0]);
    end else begin
      c_sat = (div_q > Q_HALF) ? QMIN : $signed(-div_q[QW-1:0]);
    end
  end

  assign finish = (state == S_SQ_RE && sts.big) ||
                  (state == S_CROSS && (sts.outside || k == lim));

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = {d_mag, {(FRAC_BITS + 2){1'b0}}};
    div_divisor  = DSW'(pix_size);
    ctl          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          div_start  = 1'b1;
          state_next = S_DIV_RE;
        end
      end
      S_DIV_RE: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_IM;
        end
      end
      S_DIV_IM: begin
        if (div_done) begin
          ctl.load   = 1'b1;
          state_next = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        if (!sts.big) begin
          ctl.sq_re  = 1'b1;
          state_next = S_SQ_IM;
        end
      end
      S_SQ_IM: begin
        ctl.sq_im  = 1'b1;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        if (!finish) begin
          ctl.step   = 1'b1;
          state_next = S_SQ_RE;
        end
      end
      S_DIV_SHADE: begin
        if (div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (finish) begin
      div_dividend = DVW'({k, {SHADE_SH{1'b0}}});
      div_divisor  = lim;
      if (lim == '0) begin
        state_next = S_IDLE;
      end else begin
        div_start  = 1'b1;
        state_next = S_DIV_SHADE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (finish && lim == '0) || (state == S_DIV_SHADE && div_done);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      col_q <= col;
      size  <= size_eff;
      lim   <= max_iter;
    end
    if (div_start && !finish) sgn <= d[PIX_W];
    if (state == S_DIV_RE && div_done) cre <= c_sat;
    if (ctl.load) k <= '0;
    else if (ctl.step) k <= k + ITER_W'(1);
    if (finish) iterations <= k;
    if (finish && lim == '0) shade <= '0;
    else if (state == S_DIV_SHADE && div_done) shade <= div_q[SHADE_W-1:0];
  end

  mbe_div #(
    .DVW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  mbe_orbit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_orbit (
    .clk     (clk),
    .ctl     (ctl),
    .c_re_in (cre),
    .c_im_in (c_sat),
    .sts     (sts)
  );

endmodule

// ----- rtl/core/mbe_checker.sv -----
// port-level checks of the escape-time block and their binding
module mbe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [mbe_pkg::SHADE_W-1:0]  shade
);
  import mbe_pkg::*;

  localparam logic [SHADE_W-1:0] SHADE_TOP = SHADE_W'(256);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a word in flight");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (shade <= SHADE_TOP))
    else $error("shade above full scale");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .shade (shade)
);
